// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
// Both macros sample on clk_i and hold off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every clock edge.
`define APRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond is never true at a clock edge.
`define APRC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define APRC_ASSERT(lbl, prop, msg)
`define APRC_NEVER(lbl, cond, msg)

`endif

`endif

// File: hw/rtl/aprc_pkg.sv
package aprc_pkg;

  localparam int FieldW = 32;
  localparam int VelW   = 64;
  localparam int LaneW  = 32;
  localparam int FlagW  = 4;

  // pair_flags bit positions
  localparam int FlagDynA    = 0;
  localparam int FlagDynB    = 1;
  localparam int FlagTrigger = 2;
  localparam int FlagWasHit  = 3;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_TRIG_ENTER = 3'd1,
    EV_TRIG_STAY  = 3'd2,
    EV_COLL_ENTER = 3'd3,
    EV_COLL_STAY  = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic [FieldW-1:0] a_min_x;
    logic [FieldW-1:0] a_min_y;
    logic [FieldW-1:0] a_max_x;
    logic [FieldW-1:0] a_max_y;
    logic [FieldW-1:0] b_min_x;
    logic [FieldW-1:0] b_min_y;
    logic [FieldW-1:0] b_max_x;
    logic [FieldW-1:0] b_max_y;
    logic [VelW-1:0]   a_velocity;
    logic [VelW-1:0]   b_velocity;
    logic [FlagW-1:0]  pair_flags;
  } in_item_t;

  typedef struct packed {
    logic              overlap;
    event_kind_e       event_kind;
    logic [VelW-1:0]   a_shift;
    logic [VelW-1:0]   b_shift;
    logic [VelW-1:0]   a_velocity_new;
    logic [VelW-1:0]   b_velocity_new;
    logic              a_grounded;
    logic              b_grounded;
  } out_item_t;

endpackage

// File: hw/rtl/aprc_in_if.sv
interface aprc_in_if;
  import aprc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FieldW-1:0] a_min_x;
  logic [FieldW-1:0] a_min_y;
  logic [FieldW-1:0] a_max_x;
  logic [FieldW-1:0] a_max_y;
  logic [FieldW-1:0] b_min_x;
  logic [FieldW-1:0] b_min_y;
  logic [FieldW-1:0] b_max_x;
  logic [FieldW-1:0] b_max_y;
  logic [VelW-1:0]   a_velocity;
  logic [VelW-1:0]   b_velocity;
  logic [FlagW-1:0]  pair_flags;

  modport source (
    output valid, a_min_x, a_min_y, a_max_x, a_max_y,
    output b_min_x, b_min_y, b_max_x, b_max_y, a_velocity, b_velocity, pair_flags,
    input  ready
  );

  modport sink (
    input  valid, a_min_x, a_min_y, a_max_x, a_max_y,
    input  b_min_x, b_min_y, b_max_x, b_max_y, a_velocity, b_velocity, pair_flags,
    output ready
  );
endinterface

// File: hw/rtl/aprc_out_if.sv
interface aprc_out_if;
  import aprc_pkg::*;

  logic            valid;
  logic            ready;
  logic            overlap;
  logic [2:0]      event_kind;
  logic [VelW-1:0] a_shift;
  logic [VelW-1:0] b_shift;
  logic [VelW-1:0] a_velocity_new;
  logic [VelW-1:0] b_velocity_new;
  logic            a_grounded;
  logic            b_grounded;

  modport source (
    output valid, overlap, event_kind, a_shift, b_shift,
    output a_velocity_new, b_velocity_new, a_grounded, b_grounded,
    input  ready
  );

  modport sink (
    input  valid, overlap, event_kind, a_shift, b_shift,
    input  a_velocity_new, b_velocity_new, a_grounded, b_grounded,
    output ready
  );
endinterface

// File: hw/rtl/aprc_resolve.sv
module aprc_resolve #(
  parameter int CoordWidth = 32
) (
  input  aprc_pkg::in_item_t  item_i,
  output aprc_pkg::out_item_t result_o
);
  import aprc_pkg::*;

  localparam int CW = CoordWidth;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [CW:0]   wide_t;

  localparam crd_t CrdMax = crd_t'({1'b0, {(CW-1){1'b1}}});
  localparam crd_t CrdMin = crd_t'({1'b1, {(CW-1){1'b0}}});

  function automatic crd_t rd(logic [FieldW-1:0] v);
    return crd_t'(v[CW-1:0]);
  endfunction

  function automatic logic [CW-1:0] mag_abs(crd_t v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // +m, clamped to the signed coordinate range
  function automatic crd_t sat_pos(logic [CW-1:0] m);
    return m[CW-1] ? CrdMax : crd_t'(m);
  endfunction

  // -m, clamped to the signed coordinate range
  function automatic crd_t sat_neg(logic [CW-1:0] m);
    return (m[CW-1] && (m[CW-2:0] != '0)) ? CrdMin : crd_t'(~m + CW'(1));
  endfunction

  function automatic logic [VelW-1:0] pack_lane(logic vert, crd_t v);
    logic [LaneW-1:0] lane;
    lane = LaneW'(v);
    return vert ? {{LaneW{1'b0}}, lane} : {lane, {LaneW{1'b0}}};
  endfunction

  crd_t aminx, aminy, amaxx, amaxy, bminx, bminy, bmaxx, bmaxy;
  logic dyn_a, dyn_b, trig, was;
  logic ov;
  wide_t pen_x, pen_y, pen_x0, pen_x1, pen_y0, pen_y1;
  wide_t sum_ax, sum_ay, sum_bx, sum_by;
  logic [VelW-1:0] rv;
  crd_t rx, ry, ca, cb;
  logic vpref, vert, dir_pos, do_resolve;
  wide_t pen;
  logic [CW-1:0] mag;
  crd_t lane_pos, lane_neg;
  logic clr_a, clr_b;
  logic [VelW-1:0] va_clr, vb_clr;

  always_comb begin
    aminx = rd(item_i.a_min_x);
    aminy = rd(item_i.a_min_y);
    amaxx = rd(item_i.a_max_x);
    amaxy = rd(item_i.a_max_y);
    bminx = rd(item_i.b_min_x);
    bminy = rd(item_i.b_min_y);
    bmaxx = rd(item_i.b_max_x);
    bmaxy = rd(item_i.b_max_y);

    dyn_a = item_i.pair_flags[FlagDynA];
    dyn_b = item_i.pair_flags[FlagDynB];
    trig  = item_i.pair_flags[FlagTrigger];
    was   = item_i.pair_flags[FlagWasHit];

    ov = (aminx <= bmaxx) && (amaxx >= bminx) && (aminy <= bmaxy) && (amaxy >= bminy);

    // penetration on each axis: the smaller of the edge gaps bmax - amin and amax - bmin
    pen_x0 = wide_t'(bmaxx) - wide_t'(aminx);
    pen_x1 = wide_t'(amaxx) - wide_t'(bminx);
    pen_y0 = wide_t'(bmaxy) - wide_t'(aminy);
    pen_y1 = wide_t'(amaxy) - wide_t'(bminy);
    pen_x  = (pen_x1 < pen_x0) ? pen_x1 : pen_x0;
    pen_y  = (pen_y1 < pen_y0) ? pen_y1 : pen_y0;

    sum_ax = wide_t'(aminx) + wide_t'(amaxx);
    sum_ay = wide_t'(aminy) + wide_t'(amaxy);
    sum_bx = wide_t'(bminx) + wide_t'(bmaxx);
    sum_by = wide_t'(bminy) + wide_t'(bmaxy);

    // reference body picks the vertical bias
    rv    = dyn_a ? item_i.a_velocity : item_i.b_velocity;
    rx    = rd(rv[VelW-1:LaneW]);
    ry    = rd(rv[LaneW-1:0]);
    vpref = {mag_abs(ry), 1'b0} > {1'b0, mag_abs(rx)};
    vert  = !((pen_x < pen_y) && !vpref);

    pen     = vert ? pen_y : pen_x;
    dir_pos = vert ? (sum_ay > sum_by) : (sum_ax > sum_bx);
    // pen is positive here, so its top bit is clear
    mag     = (dyn_a && dyn_b) ? pen[CW:1] : pen[CW-1:0];

    lane_pos = sat_pos(mag);
    lane_neg = sat_neg(mag);

    do_resolve = ov && !trig && (dyn_a || dyn_b) && (pen_x > 0) && (pen_y > 0);

    // velocity component along the chosen axis
    ca = vert ? rd(item_i.a_velocity[LaneW-1:0]) : rd(item_i.a_velocity[VelW-1:LaneW]);
    cb = vert ? rd(item_i.b_velocity[LaneW-1:0]) : rd(item_i.b_velocity[VelW-1:LaneW]);
    clr_a = dir_pos ? ca[CW-1] : (!ca[CW-1] && (ca != '0));
    clr_b = dir_pos ? (!cb[CW-1] && (cb != '0)) : cb[CW-1];

    va_clr = item_i.a_velocity;
    vb_clr = item_i.b_velocity;
    if (vert) begin
      va_clr[LaneW-1:0] = '0;
      vb_clr[LaneW-1:0] = '0;
    end else begin
      va_clr[VelW-1:LaneW] = '0;
      vb_clr[VelW-1:LaneW] = '0;
    end

    result_o.overlap        = ov;
    result_o.event_kind     = EV_NONE;
    result_o.a_shift        = '0;
    result_o.b_shift        = '0;
    result_o.a_velocity_new = item_i.a_velocity;
    result_o.b_velocity_new = item_i.b_velocity;
    result_o.a_grounded     = 1'b0;
    result_o.b_grounded     = 1'b0;

    if (ov) begin
      if (trig) begin
        result_o.event_kind = was ? EV_TRIG_STAY : EV_TRIG_ENTER;
      end else begin
        result_o.event_kind = was ? EV_COLL_STAY : EV_COLL_ENTER;
      end
    end

    if (do_resolve && dyn_a) begin
      result_o.a_shift    = pack_lane(vert, dir_pos ? lane_pos : lane_neg);
      result_o.a_grounded = vert && dir_pos;
      if (clr_a) begin
        result_o.a_velocity_new = va_clr;
      end
    end
    if (do_resolve && dyn_b) begin
      result_o.b_shift    = pack_lane(vert, dir_pos ? lane_neg : lane_pos);
      result_o.b_grounded = vert && !dir_pos;
      if (clr_b) begin
        result_o.b_velocity_new = vb_clr;
      end
    end
  end

endmodule

// File: hw/rtl/aabb_pair_collision_resolver_top.sv
// Channel  Dir  Handshake     Payload
// item_i   in   valid/ready   two boxes, two packed velocities, pair_flags
// result_o out  valid/ready   overlap, event_kind, shifts, new velocities, grounded
//
// An accepted item is held in the input register, and its result in the result
// register, before result_o.valid rises; one item per cycle sustained while
// result_o.ready stays high. The whole resolve (edge compares, penetration
// subtracts, axis pick, saturation) sits between the input and result registers.
// Reset (rst_ni low, asynchronous) empties both stages; payload is not reset.
// A stall on result_o holds the result register and lets one more item fill
// the input stage before item_i.ready drops.
`include "assert_macros.svh"

module aabb_pair_collision_resolver_top #(
  parameter int COORD_WIDTH = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  aprc_in_if.sink  item_i,
  aprc_out_if.source result_o
);
  import aprc_pkg::*;

  // Input stage: hold the accepted item
  in_item_t  item_q;
  logic      s1_valid_q, s1_valid_d;
  // Output stage: hold the finished result until taken
  out_item_t res_q;
  out_item_t res_d;
  logic      out_valid_q, out_valid_d;

  logic in_fire, s1_adv;

  // Advance stage 1 when the result register is empty or being drained
  assign s1_adv       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign in_fire      = item_i.valid && item_i.ready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item on acceptance
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.a_min_x    <= item_i.a_min_x;
      item_q.a_min_y    <= item_i.a_min_y;
      item_q.a_max_x    <= item_i.a_max_x;
      item_q.a_max_y    <= item_i.a_max_y;
      item_q.b_min_x    <= item_i.b_min_x;
      item_q.b_min_y    <= item_i.b_min_y;
      item_q.b_max_x    <= item_i.b_max_x;
      item_q.b_max_y    <= item_i.b_max_y;
      item_q.a_velocity <= item_i.a_velocity;
      item_q.b_velocity <= item_i.b_velocity;
      item_q.pair_flags <= item_i.pair_flags;
    end
  end

  aprc_resolve #(
    .CoordWidth(COORD_WIDTH)
  ) u_resolve (
    .item_i  (item_q),
    .result_o(res_d)
  );

  // Load the result register as stage 1 advances
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.overlap        = res_q.overlap;
  assign result_o.event_kind     = res_q.event_kind;
  assign result_o.a_shift        = res_q.a_shift;
  assign result_o.b_shift        = res_q.b_shift;
  assign result_o.a_velocity_new = res_q.a_velocity_new;
  assign result_o.b_velocity_new = res_q.b_velocity_new;
  assign result_o.a_grounded     = res_q.a_grounded;
  assign result_o.b_grounded     = res_q.b_grounded;

  `APRC_ASSERT(a_fire_fills_s1, in_fire |=> s1_valid_q, "accepted item lost at stage 1")
  `APRC_ASSERT(a_adv_fills_out, s1_adv |=> out_valid_q, "advanced item lost at output")
  `APRC_NEVER(a_ground_excl, out_valid_q && res_q.a_grounded && res_q.b_grounded,
              "both bodies grounded on one pair")
  `APRC_NEVER(a_no_ov_no_event, out_valid_q && !res_q.overlap && (res_q.event_kind != EV_NONE),
              "event reported without overlap")
  `APRC_NEVER(a_trig_no_ground,
              out_valid_q && (res_q.a_grounded || res_q.b_grounded)
              && (res_q.event_kind != EV_COLL_ENTER) && (res_q.event_kind != EV_COLL_STAY),
              "grounded flag on a non-collision result")

endmodule
